>>> src/sphere_aabb_collision_resolve_unit_assert.svh
// Assertion macros for the checker file of this block.
// Each macro places one labeled concurrent assertion that is disabled in reset.
`ifndef SPHERE_AABB_COLLISION_RESOLVE_UNIT_ASSERT_SVH
`define SPHERE_AABB_COLLISION_RESOLVE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SACR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sacr assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SACR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sacr assertion failed");

`endif

>>> src/sacr_pkg.sv
package sacr_pkg;

    // Default coordinate width; Q16.16 at this value.
    localparam int unsigned COORD_WIDTH_DEF = 32;

    // Register stages from input capture to the output word register.
    localparam int unsigned PIPE_STAGES = 5;

endpackage

>>> src/sacr_query_if.sv
interface sacr_query_if #(
    parameter int unsigned COORD_WIDTH = sacr_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [COORD_WIDTH-2:0] radius;
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_min_z;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] box_max_z;

    modport source (
        output valid, center_x, center_y, center_z, radius,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, radius,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

>>> src/sacr_result_if.sv
interface sacr_result_if #(
    parameter int unsigned COORD_WIDTH = sacr_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] push_x;
    logic signed [COORD_WIDTH-1:0] push_z;

    modport source (
        output valid, hit, push_x, push_z,
        input  ready
    );
    modport sink (
        input  valid, hit, push_x, push_z,
        output ready
    );
endinterface

>>> src/sphere_aabb_collision_resolve_unit.sv
// Sphere versus axis-aligned box test with a push-out along x or z.
//
// A query word arrives on i_query (sphere center, radius, box corners, all
// signed Q16.16 at the default width, radius unsigned) and one result word
// leaves on o_result (hit flag and the push_x/push_z push-out). A word moves
// on a channel at a rising edge where valid and ready are both high.
//
// The datapath is a five-register pipeline: input capture, clamp and push
// formation, half-width partial products with push selection, square
// assembly, and the sum-and-compare stage that loads the output register.
// A result word is shown on o_result once its query has passed through every
// stage register in order, and one query word can be taken in every cycle
// unless all stages are full; the rate is set by the per-stage advance chain.
//
// Each stage advances when it is empty or the stage after it advances, so a
// stalled receiver freezes only the occupied tail of the pipeline and empty
// stages keep filling; i_query.ready drops once all five stages hold words.
// Reset (i_rst_n low, synchronous) empties every stage; no word is lost or
// repeated across a stall.
module sphere_aabb_collision_resolve_unit #(
    parameter int unsigned COORD_WIDTH = sacr_pkg::COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sacr_query_if.sink           i_query,
    sacr_result_if.source        o_result
);
    import sacr_pkg::*;

    localparam int unsigned W     = COORD_WIDTH;
    // Gaps that survive the per-axis reject are no larger than the radius.
    localparam int unsigned GW    = W - 1;
    localparam int unsigned LO_W  = (GW + 1) / 2;
    localparam int unsigned HI_W  = GW - LO_W;
    localparam int unsigned SQW   = 2 * GW;
    localparam int unsigned PW    = W + 2;
    localparam int unsigned LAST  = PIPE_STAGES - 1;
    // Lane order for the squaring stages.
    localparam int unsigned LN_X  = 0;
    localparam int unsigned LN_Y  = 1;
    localparam int unsigned LN_Z  = 2;
    localparam int unsigned LN_R  = 3;
    localparam int unsigned LANES = 4;

    // Distance from the center to the clamped point on one axis.
    function automatic logic [W-1:0] f_gap(
        input logic signed [W-1:0] c,
        input logic signed [W-1:0] lo,
        input logic signed [W-1:0] hi
    );
        logic signed [W-1:0] p;
        logic signed [W:0]   d;
        p = (c < lo) ? lo : c;
        if (p > hi) begin
            p = hi;
        end
        d = $signed({c[W-1], c}) - $signed({p[W-1], p});
        if (d < 0) begin
            d = -d;
        end
        return d[W-1:0];
    endfunction

    // Push toward the nearer face; lo - c - r or hi - c + r at full width.
    function automatic logic signed [PW-1:0] f_push(
        input logic signed [W-1:0] c,
        input logic        [GW-1:0] r,
        input logic signed [W-1:0] lo,
        input logic signed [W-1:0] hi
    );
        logic signed [W:0]    two_c;
        logic signed [W:0]    lo_hi;
        logic signed [PW-1:0] c_e;
        logic signed [PW-1:0] r_e;
        two_c = $signed({c, 1'b0});
        lo_hi = $signed({lo[W-1], lo}) + $signed({hi[W-1], hi});
        c_e   = $signed({{2{c[W-1]}}, c});
        r_e   = $signed({3'b000, r});
        if (two_c < lo_hi) begin
            return $signed({{2{lo[W-1]}}, lo}) - c_e - r_e;
        end
        return $signed({{2{hi[W-1]}}, hi}) - c_e + r_e;
    endfunction

    function automatic logic [PW-2:0] f_mag(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] a;
        a = (v < 0) ? -v : v;
        return a[PW-2:0];
    endfunction

    // Clip to the signed W-bit range; in range when the top three bits agree.
    function automatic logic [W-1:0] f_sat(input logic signed [PW-1:0] v);
        if ((v[PW-1:W-1] == '0) || (v[PW-1:W-1] == '1)) begin
            return v[W-1:0];
        end
        return v[PW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    // Stage occupancy and the advance chain.
    logic [LAST:0] r_valid;
    logic [LAST:0] n_adv;

    always_comb begin
        n_adv[LAST] = !r_valid[LAST] || o_result.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            n_adv[k] = !r_valid[k] || n_adv[k + 1];
        end
    end

    assign i_query.ready = n_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (n_adv[0]) begin
                r_valid[0] <= i_query.valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (n_adv[k]) begin
                    r_valid[k] <= r_valid[k - 1];
                end
            end
        end
    end

    // Stage 0: input capture.
    logic signed [W-1:0] r_cx, r_cy, r_cz;
    logic        [GW-1:0] r_rad;
    logic signed [W-1:0] r_nx, r_ny, r_nz;
    logic signed [W-1:0] r_xx, r_xy, r_xz;

    always_ff @(posedge i_clk) begin
        if (n_adv[0]) begin
            r_cx  <= i_query.center_x;
            r_cy  <= i_query.center_y;
            r_cz  <= i_query.center_z;
            r_rad <= i_query.radius;
            r_nx  <= i_query.box_min_x;
            r_ny  <= i_query.box_min_y;
            r_nz  <= i_query.box_min_z;
            r_xx  <= i_query.box_max_x;
            r_xy  <= i_query.box_max_y;
            r_xz  <= i_query.box_max_z;
        end
    end

    // Stage 1: clamp gaps, early reject and both candidate pushes.
    logic [W-1:0]         n_gx, n_gy, n_gz;
    logic                 n_far;
    logic [GW-1:0]        r1_val [LANES];
    logic                 r1_far;
    logic signed [PW-1:0] r1_px, r1_pz;

    always_comb begin
        n_gx  = f_gap(r_cx, r_nx, r_xx);
        n_gy  = f_gap(r_cy, r_ny, r_xy);
        n_gz  = f_gap(r_cz, r_nz, r_xz);
        n_far = (n_gx > {1'b0, r_rad}) || (n_gy > {1'b0, r_rad}) ||
                (n_gz > {1'b0, r_rad});
    end

    always_ff @(posedge i_clk) begin
        if (n_adv[1]) begin
            r1_val[LN_X] <= n_gx[GW-1:0];
            r1_val[LN_Y] <= n_gy[GW-1:0];
            r1_val[LN_Z] <= n_gz[GW-1:0];
            r1_val[LN_R] <= r_rad;
            r1_far       <= n_far;
            r1_px        <= f_push(r_cx, r_rad, r_nx, r_xx);
            r1_pz        <= f_push(r_cz, r_rad, r_nz, r_xz);
        end
    end

    // Stage 2: half-width partial products of each square; pick the smaller push.
    logic [2*LO_W-1:0]      r2_pp00 [LANES];
    logic [LO_W+HI_W-1:0]   r2_pp01 [LANES];
    logic [2*HI_W-1:0]      r2_pp11 [LANES];
    logic                   r2_far;
    logic [W-1:0]           r2_px, r2_pz;
    logic                   n_keep_x;

    assign n_keep_x = f_mag(r1_px) < f_mag(r1_pz);

    for (genvar g = 0; g < LANES; g++) begin : g_pp
        always_ff @(posedge i_clk) begin
            if (n_adv[2]) begin
                r2_pp00[g] <= (2*LO_W)'(r1_val[g][LO_W-1:0]) *
                              (2*LO_W)'(r1_val[g][LO_W-1:0]);
                r2_pp01[g] <= (LO_W+HI_W)'(r1_val[g][LO_W-1:0]) *
                              (LO_W+HI_W)'(r1_val[g][GW-1:LO_W]);
                r2_pp11[g] <= (2*HI_W)'(r1_val[g][GW-1:LO_W]) *
                              (2*HI_W)'(r1_val[g][GW-1:LO_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv[2]) begin
            r2_far <= r1_far;
            r2_px  <= n_keep_x ? f_sat(r1_px) : '0;
            r2_pz  <= n_keep_x ? '0 : f_sat(r1_pz);
        end
    end

    // Stage 3: assemble the four squares.
    logic [SQW-1:0] r3_sq [LANES];
    logic           r3_far;
    logic [W-1:0]   r3_px, r3_pz;

    for (genvar g = 0; g < LANES; g++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (n_adv[3]) begin
                r3_sq[g] <= (SQW'(r2_pp11[g]) << (2 * LO_W)) +
                            (SQW'(r2_pp01[g]) << (LO_W + 1)) +
                            SQW'(r2_pp00[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv[3]) begin
            r3_far <= r2_far;
            r3_px  <= r2_px;
            r3_pz  <= r2_pz;
        end
    end

    // Stage 4: exact distance compare and the output word register.
    logic [SQW+1:0] n_dist2;
    logic           n_hit;
    logic           r4_hit;
    logic [W-1:0]   r4_px, r4_pz;

    always_comb begin
        n_dist2 = (SQW+2)'(r3_sq[LN_X]) + (SQW+2)'(r3_sq[LN_Y]) +
                  (SQW+2)'(r3_sq[LN_Z]);
        n_hit   = !r3_far && !(n_dist2 > (SQW+2)'(r3_sq[LN_R]));
    end

    always_ff @(posedge i_clk) begin
        if (n_adv[LAST]) begin
            r4_hit <= n_hit;
            r4_px  <= n_hit ? r3_px : '0;
            r4_pz  <= n_hit ? r3_pz : '0;
        end
    end

    assign o_result.valid  = r_valid[LAST];
    assign o_result.hit    = r4_hit;
    assign o_result.push_x = r4_px;
    assign o_result.push_z = r4_pz;

endmodule

>>> src/sacr_checker.sv
`include "sphere_aabb_collision_resolve_unit_assert.svh"

module sacr_checker #(
    parameter int unsigned COORD_WIDTH = sacr_pkg::COORD_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_hit,
    input logic [COORD_WIDTH-1:0] i_push_x,
    input logic [COORD_WIDTH-1:0] i_push_z
);
    logic                   out_stall;
    logic [2*COORD_WIDTH:0] out_word;
    logic                   px_zero;
    logic                   pz_zero;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_word  = {i_hit, i_push_x, i_push_z};
    assign px_zero   = (i_push_x == '0);
    assign pz_zero   = (i_push_z == '0);

    // A held result word keeps its contents until it is taken.
    `SACR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_word))

    // Input backpressure only appears behind a stalled output word.
    `SACR_ASSERT_SAME(a_ready_cause, i_clk, i_rst_n, !i_in_ready, out_stall)

    // A miss carries no push-out.
    `SACR_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, i_out_valid && !i_hit, px_zero && pz_zero)

    // At most one axis carries a push-out.
    `SACR_ASSERT_SAME(a_one_axis, i_clk, i_rst_n, i_out_valid, px_zero || pz_zero)

endmodule

bind sphere_aabb_collision_resolve_unit sacr_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_sacr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_query.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_hit       (o_result.hit),
    .i_push_x    (o_result.push_x),
    .i_push_z    (o_result.push_z)
);

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CW             = sacr_pkg::COORD_WIDTH_DEF;
    localparam int     PIPE_DEPTH     = sacr_pkg::PIPE_STAGES;
    localparam longint COORD_MAX      = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint COORD_MIN      = -(longint'(1) <<< (CW - 1));
    localparam longint ONE            = 65536;
    // 0xAAAAAAAA read as a signed 32-bit value.
    localparam longint ALT_NEG        = -longint'(32'h55555556);
    localparam int     RANDOM_QUERIES = 1580;
    localparam int     IDLE_PERCENT   = 9;
    localparam int     STALL_CYCLES   = 300;
    localparam int     WATCHDOG_LIMIT = 4000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct {
        t_coord          center_x;
        t_coord          center_y;
        t_coord          center_z;
        logic [CW-2:0]   radius;
        t_coord          box_min_x;
        t_coord          box_min_y;
        t_coord          box_min_z;
        t_coord          box_max_x;
        t_coord          box_max_y;
        t_coord          box_max_z;
    } t_query;

    typedef struct {
        logic   hit;
        t_coord push_x;
        t_coord push_z;
    } t_contact;

    // Clip a wide value into the signed coordinate range. The push-out uses the
    // same saturation, so this serves both stimulus and prediction.
    function automatic t_coord clip_coord(longint v);
        if (v > COORD_MAX) begin
            return t_coord'(COORD_MAX);
        end
        if (v < COORD_MIN) begin
            return t_coord'(COORD_MIN);
        end
        return t_coord'(v);
    endfunction

    // Holds the contacts expected from the queries accepted so far and checks
    // each result word against the oldest of them.
    class collision_scoreboard;
        t_contact pending_contacts[$];
        int       mismatch_count = 0;

        // Distance from the center to the clamped point on one axis. An
        // inverted box clamps to its upper corner, as the max-then-min order
        // implies.
        static function longint unsigned axis_gap(longint c, longint lo, longint hi);
            longint p;
            longint d;
            p = (c < lo) ? lo : c;
            if (p > hi) begin
                p = hi;
            end
            d = c - p;
            return (d < 0) ? -d : d;
        endfunction

        // Push toward the nearer face, chosen by 2*c against lo+hi.
        static function longint face_push(longint c, longint r, longint lo, longint hi);
            if (2 * c < lo + hi) begin
                return lo - c - r;
            end
            return hi - c + r;
        endfunction

        static function longint unsigned magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        static function t_contact resolve_contact(t_query q);
            longint            cx;
            longint            cz;
            longint            r;
            longint            px;
            longint            pz;
            longint unsigned   gx;
            longint unsigned   gy;
            longint unsigned   gz;
            logic [127:0]      dist_sq;
            logic [127:0]      rad_sq;
            t_contact          res;
            cx = longint'(q.center_x);
            cz = longint'(q.center_z);
            r  = longint'(q.radius);
            gx = axis_gap(cx, longint'(q.box_min_x), longint'(q.box_max_x));
            gy = axis_gap(longint'(q.center_y), longint'(q.box_min_y),
                          longint'(q.box_max_y));
            gz = axis_gap(cz, longint'(q.box_min_z), longint'(q.box_max_z));
            res.hit    = 1'b0;
            res.push_x = '0;
            res.push_z = '0;
            if (gx > r || gy > r || gz > r) begin
                return res;
            end
            dist_sq = 128'(gx) * 128'(gx) + 128'(gy) * 128'(gy) + 128'(gz) * 128'(gz);
            rad_sq  = 128'(r) * 128'(r);
            if (dist_sq > rad_sq) begin
                return res;
            end
            px = face_push(cx, r, longint'(q.box_min_x), longint'(q.box_max_x));
            pz = face_push(cz, r, longint'(q.box_min_z), longint'(q.box_max_z));
            // Keep only the smaller push; a tie keeps z.
            if (magnitude(px) < magnitude(pz)) begin
                pz = 0;
            end else begin
                px = 0;
            end
            res.hit    = 1'b1;
            res.push_x = clip_coord(px);
            res.push_z = clip_coord(pz);
            return res;
        endfunction

        function void note_query(t_query q);
            pending_contacts.push_back(resolve_contact(q));
        endfunction

        function void check_result(t_contact got);
            t_contact exp;
            if (pending_contacts.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word with none expected: hit=%0d push_x=%0d push_z=%0d",
                         $time, got.hit, got.push_x, got.push_z);
                return;
            end
            exp = pending_contacts.pop_front();
            if (got.hit !== exp.hit || got.push_x !== exp.push_x
                    || got.push_z !== exp.push_z) begin
                mismatch_count++;
                $display("%0t: expected hit=%0d x=%0d z=%0d, got hit=%0d x=%0d z=%0d",
                         $time, exp.hit, exp.push_x, exp.push_z,
                         got.hit, got.push_x, got.push_z);
            end
        endfunction

        function int pending();
            return pending_contacts.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sacr_query_if  #(.COORD_WIDTH(CW)) query_if ();
    sacr_result_if #(.COORD_WIDTH(CW)) result_if ();

    sphere_aabb_collision_resolve_unit #(
        .COORD_WIDTH(CW)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (query_if),
        .o_result (result_if)
    );

    collision_scoreboard sb = new;

    // Shared by both sides: when set, neither side inserts random idle cycles.
    bit steady = 1'b0;
    // Raised by the query side to ask the result side for one long hold-off.
    bit stall_request = 1'b0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_query make_query(longint cx, longint cy, longint cz, longint r,
                                          longint nx, longint ny, longint nz,
                                          longint xx, longint xy, longint xz);
        t_query q;
        q.center_x  = clip_coord(cx);
        q.center_y  = clip_coord(cy);
        q.center_z  = clip_coord(cz);
        q.radius    = (CW - 1)'((r > COORD_MAX) ? COORD_MAX : r);
        q.box_min_x = clip_coord(nx);
        q.box_min_y = clip_coord(ny);
        q.box_min_z = clip_coord(nz);
        q.box_max_x = clip_coord(xx);
        q.box_max_y = clip_coord(xy);
        q.box_max_z = clip_coord(xz);
        return q;
    endfunction

    // Uniform signed value in [-2^e, 2^e).
    function automatic longint span(int e);
        logic [63:0] u;
        u = {$urandom, $urandom};
        return longint'(u & ((64'd1 << (e + 1)) - 64'd1)) - (longint'(1) <<< e);
    endfunction

    // Most queries are boxes of a random scale with the sphere placed near
    // them, so hits, misses and both face choices all show up often. A share
    // flips some axes to inverted boxes, and the rest is raw noise that covers
    // every bit of every field.
    function automatic t_query random_query();
        int     mode;
        int     e;
        longint lo[3];
        longint hi[3];
        longint c[3];
        longint len;
        longint tmp;
        longint r;
        t_query q;
        mode = $urandom_range(99);
        if (mode < 15) begin
            q.center_x  = $urandom;
            q.center_y  = $urandom;
            q.center_z  = $urandom;
            q.radius    = (CW - 1)'($urandom);
            q.box_min_x = $urandom;
            q.box_min_y = $urandom;
            q.box_min_z = $urandom;
            q.box_max_x = $urandom;
            q.box_max_y = $urandom;
            q.box_max_z = $urandom;
            return q;
        end
        e = $urandom_range(2, 31);
        for (int a = 0; a < 3; a++) begin
            lo[a] = span(e);
            len   = span(e - 1) + (longint'(1) <<< (e - 1));
            hi[a] = lo[a] + len;
            c[a]  = lo[a] + len / 2 + span(e);
            if (mode < 30 && $urandom_range(1) == 1) begin
                tmp   = lo[a];
                lo[a] = hi[a];
                hi[a] = tmp;
            end
        end
        r = span(e - 1) + (longint'(1) <<< (e - 1));
        return make_query(c[0], c[1], c[2], r, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    task automatic drive_fields(t_query q);
        query_if.center_x  <= q.center_x;
        query_if.center_y  <= q.center_y;
        query_if.center_z  <= q.center_z;
        query_if.radius    <= q.radius;
        query_if.box_min_x <= q.box_min_x;
        query_if.box_min_y <= q.box_min_y;
        query_if.box_min_z <= q.box_min_z;
        query_if.box_max_x <= q.box_max_x;
        query_if.box_max_y <= q.box_max_y;
        query_if.box_max_z <= q.box_max_z;
    endtask

    // Offer one query word and hold it until the block takes it. Valid stays
    // high into the next word unless a random idle cycle is drawn.
    task automatic send_query(t_query q);
        drive_fields(q);
        query_if.valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!query_if.ready);
        sb.note_query(q);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            query_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stop offering queries until every expected result word has come back.
    // The loop waits on a clock edge before it checks, so valid is never driven twice in one step.
    task automatic drain_results();
        query_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pending() != 0);
    endtask

    // Query side: reset, a directed set of corner cases, then random traffic
    // with one long receiver stall, one full drain and one stretch without any
    // idle cycles.
    initial begin
        t_query idle_query;
        idle_query = make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        i_rst_n        <= 1'b0;
        query_if.valid <= 1'b0;
        drive_fields(idle_query);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero radius with the center inside the box: a hit, and the equal x
        // and z pushes tie, so z is kept.
        send_query(make_query(0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // Zero radius with the center outside the box: no hit.
        send_query(make_query(2 * ONE, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // Sphere just touching a face counts as a hit; one step further does not.
        send_query(make_query(ONE + ONE / 2, 0, 0, ONE / 2,
                              -ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_query(make_query(ONE + ONE / 2, 0, 0, ONE / 2 - 1,
                              -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // Near a corner every axis gap fits the radius, but the summed squares
        // decide: first a miss, then a hit.
        send_query(make_query(2 * ONE, 2 * ONE, 2 * ONE, ONE + ONE / 2,
                              -ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_query(make_query(2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE,
                              -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // The x push is the smaller one, then the z push, on the upper faces.
        send_query(make_query(ONE / 2, 0, 0, ONE / 4,
                              -ONE, -ONE, -4 * ONE, ONE, ONE, 4 * ONE));
        send_query(make_query(0, 0, ONE / 2, ONE / 4,
                              -4 * ONE, -ONE, -ONE, 4 * ONE, ONE, ONE));
        // Lower faces give negative pushes.
        send_query(make_query(-ONE / 2, 0, -3 * ONE, ONE / 8,
                              -ONE, -ONE, -4 * ONE, ONE, ONE, 4 * ONE));
        send_query(make_query(-3 * ONE, 0, -ONE / 2, ONE / 8,
                              -4 * ONE, -ONE, -ONE, 4 * ONE, ONE, ONE));
        // Negative pushes of equal size: z is kept.
        send_query(make_query(-ONE / 2, 0, -ONE / 2, ONE / 8,
                              -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // Inverted box on x: the closest point is the upper corner.
        send_query(make_query(0, 0, 0, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE));
        send_query(make_query(5 * ONE, 0, 0, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE));
        // Inverted box on all three axes.
        send_query(make_query(0, 0, 0, 2 * ONE, ONE, ONE, ONE, -ONE, -ONE, -ONE));
        // Degenerate point box.
        send_query(make_query(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        // Pushes beyond the coordinate range saturate, high and low.
        send_query(make_query(0, 0, 0, COORD_MAX,
                              COORD_MIN, -ONE, COORD_MIN, COORD_MAX, ONE, COORD_MAX));
        send_query(make_query(-1, 0, -1, COORD_MAX,
                              COORD_MIN, -ONE, COORD_MIN, COORD_MAX, ONE, COORD_MAX));
        // Every field at its lowest, then every field at its highest.
        send_query(make_query(COORD_MIN, COORD_MIN, COORD_MIN, 0,
                              COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MIN, COORD_MIN, COORD_MIN));
        send_query(make_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MAX));
        // Widest possible gaps, far beyond any radius.
        send_query(make_query(COORD_MIN, 0, 0, COORD_MAX,
                              COORD_MAX, 0, 0, COORD_MAX, 0, 0));
        send_query(make_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MIN, COORD_MIN, COORD_MIN));
        // Alternating bit patterns in every field.
        send_query(make_query(32'h55555555, ALT_NEG, 32'h55555555, 32'h2AAAAAAA,
                              ALT_NEG, 32'h55555555, ALT_NEG,
                              32'h55555555, ALT_NEG, 32'h55555555));

        for (int n = 0; n < RANDOM_QUERIES; n++) begin
            if (n == 400) begin
                // The result side holds off while queries keep coming, so the
                // pipeline fills and the query channel must back up.
                stall_request = 1'b1;
            end
            if (n == 800) begin
                drain_results();
            end
            steady = (n >= 1000 && n < 1300);
            send_query(random_query());
        end
        steady = 1'b0;

        drain_results();
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected result words never arrived", $time, sb.pending());
        end
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: check each accepted word, then pick ready for the next
    // cycle. A requested hold-off is counted here, cycle by cycle.
    initial begin
        t_contact got;
        int       hold_left;
        hold_left       = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready) begin
                got.hit    = result_if.hit;
                got.push_x = result_if.push_x;
                got.push_z = result_if.push_z;
                sb.check_result(got);
            end
            if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (steady) begin
                result_if.ready <= 1'b1;
            end else begin
                result_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Watchdog: a long run of cycles with no word moving on either channel
    // means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (query_if.valid && query_if.ready)
                || (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
